// File: rtl/core/hsvg_pkg.sv
package hsvg_pkg;

    localparam logic [7:0] SECTOR_1 = 8'd43;
    localparam logic [7:0] SECTOR_2 = 8'd85;
    localparam logic [7:0] SECTOR_3 = 8'd128;
    localparam logic [7:0] SECTOR_4 = 8'd171;
    localparam logic [7:0] SECTOR_5 = 8'd213;
    localparam logic [7:0] CHAN_FULL = 8'd255;
    localparam logic [7:0] SAT_BUMP = 8'd128;

    // floor(o * 255 / 43) for sector offsets 0..42; unused offsets read zero
    localparam logic [7:0] RAMP_LUT [64] = '{
        8'd0,   8'd5,   8'd11,  8'd17,  8'd23,  8'd29,  8'd35,  8'd41,
        8'd47,  8'd53,  8'd59,  8'd65,  8'd71,  8'd77,  8'd83,  8'd88,
        8'd94,  8'd100, 8'd106, 8'd112, 8'd118, 8'd124, 8'd130, 8'd136,
        8'd142, 8'd148, 8'd154, 8'd160, 8'd166, 8'd171, 8'd177, 8'd183,
        8'd189, 8'd195, 8'd201, 8'd207, 8'd213, 8'd219, 8'd225, 8'd231,
        8'd237, 8'd243, 8'd249, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
    };

    localparam logic [7:0] GAMMA_ROM [256] = '{
        8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
        8'd10,  8'd10,  8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd14,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
        8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
        8'd21,  8'd21,  8'd22,  8'd23,  8'd23,  8'd24,  8'd24,  8'd25,
        8'd26,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
        8'd31,  8'd31,  8'd32,  8'd33,  8'd34,  8'd34,  8'd35,  8'd36,
        8'd36,  8'd37,  8'd38,  8'd39,  8'd40,  8'd40,  8'd41,  8'd42,
        8'd43,  8'd44,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,
        8'd50,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,
        8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,
        8'd65,  8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,
        8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,  8'd82,
        8'd83,  8'd84,  8'd85,  8'd86,  8'd88,  8'd89,  8'd90,  8'd91,
        8'd92,  8'd94,  8'd95,  8'd96,  8'd98,  8'd99,  8'd100, 8'd101,
        8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd110, 8'd111, 8'd112,
        8'd114, 8'd115, 8'd117, 8'd118, 8'd120, 8'd121, 8'd122, 8'd124,
        8'd125, 8'd127, 8'd128, 8'd130, 8'd131, 8'd133, 8'd134, 8'd136,
        8'd138, 8'd139, 8'd141, 8'd142, 8'd144, 8'd146, 8'd147, 8'd149,
        8'd150, 8'd152, 8'd154, 8'd155, 8'd157, 8'd159, 8'd160, 8'd162,
        8'd164, 8'd166, 8'd167, 8'd169, 8'd171, 8'd173, 8'd174, 8'd176,
        8'd178, 8'd180, 8'd182, 8'd183, 8'd185, 8'd187, 8'd189, 8'd191,
        8'd193, 8'd195, 8'd197, 8'd198, 8'd200, 8'd202, 8'd204, 8'd206,
        8'd208, 8'd210, 8'd212, 8'd214, 8'd216, 8'd218, 8'd220, 8'd222,
        8'd224, 8'd226, 8'd228, 8'd230, 8'd232, 8'd235, 8'd237, 8'd239,
        8'd241, 8'd243, 8'd245, 8'd247, 8'd249, 8'd252, 8'd254, 8'd255
    };

    // raw sector color plus the blend/scale operands
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [8:0] sat;
        logic [7:0] val;
        logic       gam;
    } pix_t;

    // shaded color waiting for the gamma lookup
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       gam;
    } rgb_t;

endpackage

// File: rtl/core/hsvg_sector.sv
module hsvg_sector
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        hue,
    input  logic [7:0]        saturation,
    input  logic [7:0]        brightness,
    input  logic              apply_gamma,
    output logic              out_valid,
    input  logic              out_ready,
    output hsvg_pkg::pix_t    out_data
);
    import hsvg_pkg::*;

    logic       valid_reg;
    pix_t       data_reg;
    pix_t       data_next;
    logic [7:0] off;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next     = '0;
        off           = 8'd0;
        data_next.val = brightness;
        data_next.gam = apply_gamma;
        // saturation above the midpoint is bumped so that 255 maps to 256
        data_next.sat = (saturation > SAT_BUMP) ? {1'b0, saturation} + 9'd1
                                                : {1'b0, saturation};
        if (hue < SECTOR_1)
        begin
            off         = hue;
            data_next.r = CHAN_FULL;
            data_next.g = RAMP_LUT[off[5:0]];
        end
        else if (hue < SECTOR_2)
        begin
            off         = hue - SECTOR_1;
            data_next.g = CHAN_FULL;
            data_next.r = CHAN_FULL - RAMP_LUT[off[5:0]];
        end
        else if (hue < SECTOR_3)
        begin
            off         = hue - SECTOR_2;
            data_next.g = CHAN_FULL;
            data_next.b = RAMP_LUT[off[5:0]];
        end
        else if (hue < SECTOR_4)
        begin
            off         = hue - SECTOR_3;
            data_next.b = CHAN_FULL;
            data_next.g = CHAN_FULL - RAMP_LUT[off[5:0]];
        end
        else if (hue < SECTOR_5)
        begin
            off         = hue - SECTOR_4;
            data_next.b = CHAN_FULL;
            data_next.r = RAMP_LUT[off[5:0]];
        end
        else
        begin
            off         = hue - SECTOR_5;
            data_next.r = CHAN_FULL;
            data_next.b = CHAN_FULL - RAMP_LUT[off[5:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/core/hsvg_shade.sv
module hsvg_shade
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsvg_pkg::pix_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hsvg_pkg::rgb_t    out_data
);
    import hsvg_pkg::*;

    // blend toward white: (c * s + 255 * (256 - s)) >> 8
    function automatic logic [7:0] blend(input logic [7:0] c, input logic [8:0] s);
        logic [16:0] sum;
        sum = 17'(c) * 17'(s) + 17'(CHAN_FULL) * (17'd256 - 17'(s));
        return sum[15:8];
    endfunction

    function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] v);
        logic [15:0] prod;
        prod = 16'(c) * 16'(v);
        return prod[15:8];
    endfunction

    logic  a_valid_reg;
    logic  a_ready;
    rgb_t  a_reg;
    rgb_t  a_next;
    logic [7:0] a_val_reg;
    logic  b_valid_reg;
    logic  b_ready;
    rgb_t  b_reg;
    rgb_t  b_next;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign up_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

    always_comb
    begin
        a_next.r   = blend(in_data.r, in_data.sat);
        a_next.g   = blend(in_data.g, in_data.sat);
        a_next.b   = blend(in_data.b, in_data.sat);
        a_next.gam = in_data.gam;
        b_next.r   = scale(a_reg.r, a_val_reg);
        b_next.g   = scale(a_reg.g, a_val_reg);
        b_next.b   = scale(a_reg.b, a_val_reg);
        b_next.gam = a_reg.gam;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_reg     <= a_next;
            a_val_reg <= in_data.val;
        end
        if (b_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

endmodule

// File: rtl/core/hsvg_gamma.sv
module hsvg_gamma
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsvg_pkg::rgb_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue
);
    import hsvg_pkg::*;

    logic       valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    assign up_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    always_comb
    begin
        red_next   = in_data.gam ? GAMMA_ROM[in_data.r] : in_data.r;
        green_next = in_data.gam ? GAMMA_ROM[in_data.g] : in_data.g;
        blue_next  = in_data.gam ? GAMMA_ROM[in_data.b] : in_data.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

// File: rtl/core/hsv_to_rgb_gamma_unit.sv
// HSV to RGB color converter with optional gamma correction.
//
// Input stream (s_*): one word per pixel. s_tdata carries hue, saturation
// and brightness; s_tuser set means the result goes through the gamma table.
// Output stream (m_*): one word per input word, in order, red/green/blue.
//
// Four register stages: sector decode and ramp lookup, saturation blend
// (one 8x9 multiply per channel), brightness scale (one 8x8 multiply per
// channel), gamma lookup into the output register. Throughput is one pixel
// per clock while m_tready stays high.
//
// Each stage holds its own valid bit and moves whenever the stage after it
// is empty or moving, so bubbles are squeezed out. When the receiver drops
// m_tready the output word holds and the stages behind it keep filling; the
// input sees s_tready low only once all four stages are full. Nothing is
// dropped or repeated.
//
// Reset (rst_n low, asynchronous) empties the pipeline; no other state.
module hsv_to_rgb_gamma_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hue[7:0], saturation[15:8], brightness[23:16]
    input  logic        s_tuser,   // apply_gamma[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import hsvg_pkg::*;

    logic  st1_valid;
    logic  st1_ready;
    pix_t  st1_data;
    logic  st3_valid;
    logic  st3_ready;
    rgb_t  st3_data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    hsvg_sector u_sector
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .hue         (s_tdata[7:0]),
        .saturation  (s_tdata[15:8]),
        .brightness  (s_tdata[23:16]),
        .apply_gamma (s_tuser),
        .out_valid   (st1_valid),
        .out_ready   (st1_ready),
        .out_data    (st1_data)
    );

    hsvg_shade u_shade
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (st1_valid),
        .up_ready  (st1_ready),
        .in_data   (st1_data),
        .out_valid (st3_valid),
        .out_ready (st3_ready),
        .out_data  (st3_data)
    );

    hsvg_gamma u_gamma
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (st3_valid),
        .up_ready  (st3_ready),
        .in_data   (st3_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {blue, green, red};

`ifndef SYNTHESIS
    a_accept_fills_st1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> st1_valid)
        else $error("accepted word did not reach first stage");

    a_st1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (st1_valid && !st1_ready) |=> (st1_valid && $stable(st1_data)))
        else $error("stalled first stage lost its word");

    a_no_gamma_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (st3_valid && st3_ready && !st3_data.gam) |=>
        (m_tvalid && m_tdata == $past({st3_data.b, st3_data.g, st3_data.r})))
        else $error("ungamma'd word changed in output stage");
`endif

endmodule
